// ===== sv/codel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package codel_pkg;

    localparam int RSQRT_FRAC_BITS_DEF = 16;

    localparam int CMD_W   = 2;
    localparam int TIME_W  = 32;
    localparam int BYTES_W = 16;
    localparam int BKLG_W  = 24;
    localparam int QPK_W   = 16;
    localparam int IVL_W   = 24;
    localparam int TGT_W   = 24;
    localparam int QLIM_W  = 16;
    localparam int CNT_W   = 16;
    localparam int VERD_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QLIMIT   = 2'd2;

    localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ    = 2'd1;

    typedef enum logic [VERD_W-1:0] {
        V_DELIVER  = 3'd0,
        V_DROP     = 3'd1,
        V_EMPTY    = 3'd2,
        V_ACCEPT   = 3'd3,
        V_TAILDROP = 3'd4
    } t_verdict;

    typedef struct packed {
        logic load;
        logic track;
        logic rsq_start;
        logic arm_wr;
        logic upd;
        logic ndt_wr;
        logic fin_drop;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_arrival;
        logic need_rsq1;
        logic need_rsq2;
        logic rsq_done;
    } t_stat;

endpackage
`default_nettype wire

// ===== sv/codel_rsq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// delta = (interval * floor(2^F / sqrt(max(c,1)))) >> F
// bit-serial divide of 2^2F by c, then digit-by-digit square root, then one multiply
module codel_rsq import codel_pkg::*; #(
    parameter int F = RSQRT_FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic [IVL_W-1:0] i_interval,
    output logic                  o_done,
    output logic [IVL_W-1:0]      o_delta
);
    localparam int QW = 2 * F + 1;
    localparam int RW = F + 1;
    localparam int SW = 2 * RW;
    localparam int PW = IVL_W + RW;
    localparam int KW = $clog2(QW + 1);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_SQRT, S_MUL, S_DONE} t_state;

    t_state            r_state;
    logic [KW-1:0]     r_cnt;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    r_rem;
    logic [QW-1:0]     r_q;
    logic [SW-1:0]     r_s;
    logic [RW+1:0]     r_r;
    logic [RW-1:0]     r_y;
    logic [PW-1:0]     r_prod;

    logic [CNT_W:0]    rem_sh;
    logic              q_bit;
    logic [CNT_W:0]    n_rem;
    logic [QW-1:0]     n_q;
    logic [RW+1:0]     r_sh;
    logic [RW+1:0]     trial;
    logic [RW+1:0]     n_r;
    logic [RW-1:0]     n_y;

    always_comb begin
        rem_sh = {r_rem[CNT_W-1:0], (r_cnt == KW'(2 * F))};
        q_bit  = (rem_sh >= {1'b0, r_div});
        n_rem  = q_bit ? (rem_sh - {1'b0, r_div}) : rem_sh;
        n_q    = {r_q[QW-2:0], q_bit};
        r_sh   = {r_r[RW-1:0], r_s[SW-1:SW-2]};
        trial  = {r_y, 2'b01};
        if (r_sh >= trial) begin
            n_r = r_sh - trial;
            n_y = {r_y[RW-2:0], 1'b1};
        end else begin
            n_r = r_sh;
            n_y = {r_y[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_div   <= (i_count == '0) ? CNT_W'(1) : i_count;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_cnt   <= KW'(QW - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    if (r_cnt == '0) begin
                        r_s     <= {1'b0, n_q};
                        r_r     <= '0;
                        r_y     <= '0;
                        r_cnt   <= KW'(RW - 1);
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_SQRT: begin
                    r_r <= n_r;
                    r_y <= n_y;
                    r_s <= {r_s[SW-3:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(i_interval) * PW'(r_y);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == S_DONE);
    assign o_delta = r_prod[F +: IVL_W];

endmodule
`default_nettype wire

// ===== sv/codel_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module codel_dp import codel_pkg::*; #(
    parameter int RSQRT_FRAC_BITS = RSQRT_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [TIME_W-1:0]     i_now_ticks,
    input  wire logic [TIME_W-1:0]     i_arrival_stamp,
    input  wire logic [BYTES_W-1:0]    i_packet_bytes,
    input  wire logic [BKLG_W-1:0]     i_backlog_bytes,
    input  wire logic [QPK_W-1:0]      i_queue_packets,
    output logic [VERD_W-1:0]          o_verdict,
    output logic [TIME_W-1:0]          o_stamp_out,
    output logic [TIME_W-1:0]          o_sojourn_ticks,
    output logic                       o_in_dropping
);
    logic [IVL_W-1:0]   r_interval;
    logic [TGT_W-1:0]   r_target;
    logic [QLIM_W-1:0]  r_qlimit;

    logic [CMD_W-1:0]   r_command;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_stamp;
    logic [BYTES_W-1:0] r_bytes;
    logic [BKLG_W-1:0]  r_backlog;
    logic [QPK_W-1:0]   r_qpk;

    logic               r_dropping;
    logic [CNT_W-1:0]   r_count;
    logic [TIME_W-1:0]  r_ndt;
    logic [TIME_W-1:0]  r_asd;
    logic               r_dap;
    logic [BYTES_W-1:0] r_lp;
    logic               r_rp;
    logic               r_ep;
    logic               r_ok;
    logic               r_drop;
    logic               r_br2;
    logic               r_base_now;

    logic               rsq_done;
    logic [IVL_W-1:0]   rsq_delta;

    codel_rsq #(.F(RSQRT_FRAC_BITS)) u_rsq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.rsq_start),
        .i_count    (r_count),
        .i_interval (r_interval),
        .o_done     (rsq_done),
        .o_delta    (rsq_delta)
    );

    logic               have;
    logic [TIME_W-1:0]  sojourn;
    logic [BYTES_W-1:0] lp_new;
    logic               below;
    logic               arm;
    logic               recent;
    logic [TIME_W-1:0]  rd_diff;
    logic [TIME_W-1:0]  asd_diff;
    logic [TIME_W-1:0]  ndt_diff;
    logic [CNT_W+5:0]   decay;
    logic [CNT_W-1:0]   cnt_m2;
    t_verdict           verd;

    always_comb begin
        have     = (r_command == CMD_DEQ);
        sojourn  = r_now - r_stamp;
        lp_new   = (have && (r_lp < r_bytes)) ? r_bytes : r_lp;
        below    = (sojourn < TIME_W'(r_target)) || (r_backlog <= BKLG_W'(lp_new));
        arm      = !r_dap && (r_asd == '0);
        rd_diff  = r_now - r_ndt;
        // signed difference below 8 * interval; negative always qualifies
        recent   = rd_diff[TIME_W-1] ||
                   (rd_diff[TIME_W-2:0] < (TIME_W-1)'({r_interval, 3'b000}));
        asd_diff = r_now - r_asd;
        ndt_diff = r_now - r_ndt;
        cnt_m2   = r_count - CNT_W'(2);
        decay    = ({r_count, 6'b0} - (CNT_W+6)'(r_count)) >> 6;
        if (r_command == CMD_ARRIVE) begin
            verd = (r_qpk >= r_qlimit) ? V_TAILDROP : V_ACCEPT;
        end else if (r_drop) begin
            verd = V_DROP;
        end else begin
            verd = have ? V_DELIVER : V_EMPTY;
        end
    end

    always_comb begin
        o_stat.is_arrival = (r_command == CMD_ARRIVE);
        o_stat.need_rsq1  = have && !below && arm && recent && (r_count > CNT_W'(1));
        o_stat.need_rsq2  = r_ep || (r_rp && r_ok);
        o_stat.rsq_done   = rsq_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= IVL_W'(100000);
            r_target   <= TGT_W'(5000);
            r_qlimit   <= QLIM_W'(50);
            r_dropping <= 1'b0;
            r_count    <= '0;
            r_ndt      <= '0;
            r_asd      <= '0;
            r_dap      <= 1'b1;
            r_lp       <= BYTES_W'(256);
            r_rp       <= 1'b0;
            r_ep       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INTERVAL: r_interval <= i_cfg_data[IVL_W-1:0];
                    CFG_TARGET:   r_target   <= i_cfg_data[TGT_W-1:0];
                    CFG_QLIMIT:   r_qlimit   <= i_cfg_data[QLIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.track) begin
                r_lp <= lp_new;
                r_ok <= 1'b0;
                if (!have || below) begin
                    r_asd <= '0;
                    r_dap <= 1'b0;
                end else if (arm) begin
                    if (!(recent && (r_count > CNT_W'(1)))) begin
                        r_asd <= r_now + TIME_W'(r_interval);
                    end
                end else begin
                    r_ok <= r_dap || !asd_diff[TIME_W-1];
                end
            end
            if (i_cmd.arm_wr) begin
                r_asd <= r_now + TIME_W'(rsq_delta);
            end
            if (i_cmd.upd) begin
                r_drop <= 1'b0;
                r_br2  <= 1'b0;
                if (r_ep) begin
                    r_ep       <= 1'b0;
                    r_dropping <= 1'b1;
                    r_base_now <= 1'b1;
                    if ((r_count > CNT_W'(2)) && recent) begin
                        r_count <= (cnt_m2 > CNT_W'(126)) ? decay[CNT_W-1:0] : cnt_m2;
                    end else begin
                        r_count <= CNT_W'(1);
                    end
                end else if (r_rp || r_dropping) begin
                    r_br2 <= 1'b1;
                    if (r_rp) begin
                        r_rp <= 1'b0;
                        if (!r_ok) begin
                            r_dropping <= 1'b0;
                        end else begin
                            r_base_now <= 1'b0;
                            if (r_count != '1) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                    end else if (!r_ok) begin
                        r_dropping <= 1'b0;
                    end
                end else if (r_ok) begin
                    r_drop <= 1'b1;
                    r_ep   <= 1'b1;
                end
            end
            if (i_cmd.ndt_wr) begin
                r_ndt <= (r_base_now ? r_now : r_ndt) + TIME_W'(rsq_delta);
            end
            if (i_cmd.fin_drop) begin
                if (r_br2 && r_dropping && have && !ndt_diff[TIME_W-1]) begin
                    r_drop <= 1'b1;
                    r_rp   <= 1'b1;
                end
            end
        end
    end

    // input latch and result registers: payload only
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_now     <= i_now_ticks;
            r_stamp   <= i_arrival_stamp;
            r_bytes   <= i_packet_bytes;
            r_backlog <= i_backlog_bytes;
            r_qpk     <= i_queue_packets;
        end
        if (i_cmd.finish) begin
            o_verdict       <= verd;
            o_stamp_out     <= (verd == V_ACCEPT) ? r_now : '0;
            o_sojourn_ticks <= have ? sojourn : '0;
            o_in_dropping   <= r_dropping;
        end
    end

endmodule
`default_nettype wire

// ===== sv/codel_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module codel_ctrl import codel_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_TRACK, S_WAIT1, S_UPD, S_START2, S_WAIT2, S_FINAL, S_OUT
    } t_state;

    t_state r_state;
    logic   out_free;

    assign out_free   = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.track     = (r_state == S_TRACK) && !i_stat.is_arrival;
        o_cmd.rsq_start = ((r_state == S_TRACK) && !i_stat.is_arrival && i_stat.need_rsq1) ||
                          (r_state == S_START2);
        o_cmd.arm_wr    = (r_state == S_WAIT1) && i_stat.rsq_done;
        o_cmd.upd       = (r_state == S_UPD);
        o_cmd.ndt_wr    = (r_state == S_WAIT2) && i_stat.rsq_done;
        o_cmd.fin_drop  = (r_state == S_FINAL);
        o_cmd.finish    = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (o_cmd.finish) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_TRACK;
                end
                S_TRACK: begin
                    if (i_stat.is_arrival) r_state <= S_OUT;
                    else if (i_stat.need_rsq1) r_state <= S_WAIT1;
                    else r_state <= S_UPD;
                end
                S_WAIT1: begin
                    if (i_stat.rsq_done) r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state <= i_stat.need_rsq2 ? S_START2 : S_FINAL;
                end
                S_START2: r_state <= S_WAIT2;
                S_WAIT2: begin
                    if (i_stat.rsq_done) r_state <= S_FINAL;
                end
                S_FINAL: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/codel_drop_controller_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// CoDel drop decision engine. One event beat in, one verdict beat out.
// Input channel (i_in_valid / o_in_ready): command 0 arrival, 1 dequeued head
// packet, 2 or 3 empty dequeue, with time, stamp, sizes and queue depth.
// Output channel (o_out_valid / i_out_ready): verdict, stamp, sojourn and the
// dropping flag after the event.
// An arrival runs no reciprocal square root pass (F = RSQRT_FRAC_BITS fraction
// bits). A dequeue runs one when the above-target deadline is armed from the
// control law, and another when a drop updates the next drop time. That unit
// (bit-serial divide, then square root, then one multiply) sets the rate; one
// event is worked at a time, and the next beat is taken the cycle after the
// result is loaded.
// Configuration writes (i_cfg_we) take effect at once; write while idle.
// Reset (synchronous, active low) restores register defaults and clears the
// dropping state. When the receiver stalls, the verdict is held in the output
// register; the next event may be taken and worked up to its result.
module codel_drop_controller_top import codel_pkg::*; #(
    parameter int RSQRT_FRAC_BITS = RSQRT_FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [TIME_W-1:0]     i_now_ticks,
    input  wire logic [TIME_W-1:0]     i_arrival_stamp,
    input  wire logic [BYTES_W-1:0]    i_packet_bytes,
    input  wire logic [BKLG_W-1:0]     i_backlog_bytes,
    input  wire logic [QPK_W-1:0]      i_queue_packets,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [VERD_W-1:0]          o_verdict,
    output logic [TIME_W-1:0]          o_stamp_out,
    output logic [TIME_W-1:0]          o_sojourn_ticks,
    output logic                       o_in_dropping
);
    t_cmd  cmd;
    t_stat stat;

    codel_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    codel_dp #(.RSQRT_FRAC_BITS(RSQRT_FRAC_BITS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_now_ticks     (i_now_ticks),
        .i_arrival_stamp (i_arrival_stamp),
        .i_packet_bytes  (i_packet_bytes),
        .i_backlog_bytes (i_backlog_bytes),
        .i_queue_packets (i_queue_packets),
        .o_verdict       (o_verdict),
        .o_stamp_out     (o_stamp_out),
        .o_sojourn_ticks (o_sojourn_ticks),
        .o_in_dropping   (o_in_dropping)
    );

endmodule
`default_nettype wire

// ===== sv/codel_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module codel_checker import codel_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [VERD_W-1:0] o_verdict,
    input wire logic [TIME_W-1:0] o_stamp_out,
    input wire logic [TIME_W-1:0] o_sojourn_ticks
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict))
        else $error("stalled verdict changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second event taken while busy");

    a_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict != V_ACCEPT) |-> (o_stamp_out == '0))
        else $error("stamp on non-accept verdict");

    a_soj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_verdict == V_ACCEPT) || (o_verdict == V_TAILDROP) ||
                        (o_verdict == V_EMPTY)) |-> (o_sojourn_ticks == '0))
        else $error("sojourn on event without packet");

endmodule

bind codel_drop_controller_top codel_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_verdict       (o_verdict),
    .o_stamp_out     (o_stamp_out),
    .o_sojourn_ticks (o_sojourn_ticks)
);
`default_nettype wire
